// File: rtl/sgam_pkg.sv
// ---------------------------------------------------------------------------
// sgam_pkg
// Shared widths, codes and the queue entry type of the semiglobal matrix fill.
// ---------------------------------------------------------------------------
package sgam_pkg;

  localparam int SCORE_W  = 24;
  localparam int COST_W   = 16;
  localparam int WEIGHT_W = 16;
  localparam int CODE_W   = 5;
  // one bit of headroom over a score plus a cost, one more for safety
  localparam int SUM_W    = 26;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // saturation limits at full precision
  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'((1 << (SCORE_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(1 << (SCORE_W - 1));

  // request kinds
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CELL  = 1'b1;

  // direction codes
  localparam logic [1:0] FROM_DIAG = 2'd0;
  localparam logic [1:0] FROM_LEFT = 2'd1;
  localparam logic [1:0] FROM_UP   = 2'd2;

  // configuration register indexes
  localparam logic CFG_GAP_OPEN   = 1'b0;
  localparam logic CFG_GAP_EXTEND = 1'b1;

  // classified request as it waits in the queue
  typedef struct packed {
    logic                       is_cell;
    logic                       in_alpha;
    logic [CODE_W-1:0]          code_first;
    logic [CODE_W-1:0]          code_second;
    logic signed [WEIGHT_W-1:0] table_weight;
    logic                       row_end;
    logic                       final_row;
  } sgam_item_t;

endpackage

// File: rtl/sgam_front.sv
// ---------------------------------------------------------------------------
// sgam_front
// Accepts stream requests, unpacks the fields and classifies each request
// as a table write or a matrix cell, with its alphabet range check.
// ---------------------------------------------------------------------------
module sgam_front #(
  parameter int ALPHABET_SIZE = 32
) (
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [31:0]          s_tdata,   // code_first[4:0], code_second[9:5],
                                          // table_weight[25:10], zero pad
  input  logic [1:0]           s_tuser,   // op[0], final_row[1]
  input  logic                 s_tlast,   // row_end
  output logic                 push,
  input  logic                 push_ready,
  output sgam_pkg::sgam_item_t item
);

  logic [sgam_pkg::CODE_W-1:0] code_first;
  logic [sgam_pkg::CODE_W-1:0] code_second;

  assign code_first  = s_tdata[4:0];
  assign code_second = s_tdata[9:5];

  // pass the handshake straight to the queue
  assign push     = s_tvalid;
  assign s_tready = push_ready;

  // classify the request
  always_comb begin
    item.is_cell      = (s_tuser[0] == sgam_pkg::OP_CELL);
    item.in_alpha     = (int'(code_first) < ALPHABET_SIZE) &&
                        (int'(code_second) < ALPHABET_SIZE);
    item.code_first   = code_first;
    item.code_second  = code_second;
    item.table_weight = s_tdata[25:10];
    item.row_end      = s_tlast;
    item.final_row    = s_tuser[1];
  end

endmodule

// File: rtl/sgam_queue.sv
// ---------------------------------------------------------------------------
// sgam_queue
// Short FIFO between the front and the back so that each side stalls alone.
// ---------------------------------------------------------------------------
module sgam_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 push_ready,
  input  sgam_pkg::sgam_item_t push_item,
  output logic                 pop_valid,
  input  logic                 pop,
  output sgam_pkg::sgam_item_t pop_item
);

  sgam_pkg::sgam_item_t slots [sgam_pkg::QUEUE_DEPTH];

  logic [sgam_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [sgam_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [sgam_pkg::QUEUE_CNT_W-1:0] count;
  logic                             do_push;
  logic                             do_pop;

  assign push_ready = (count != sgam_pkg::QUEUE_CNT_W'(sgam_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_item   = slots[rd_ptr];

  // store the entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == sgam_pkg::QUEUE_PTR_W'(sgam_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == sgam_pkg::QUEUE_PTR_W'(sgam_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/sgam_back.sv
// ---------------------------------------------------------------------------
// sgam_back
// Executes queued requests: table writes, and cell scoring through a read
// stage (table and upper-row memories) and a scoring stage with an output
// register. Holds the gap cost registers.
// ---------------------------------------------------------------------------
module sgam_back #(
  parameter int MAX_ROW_LEN   = 1024,
  parameter int ALPHABET_SIZE = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic                               cfg_index,
  input  logic [sgam_pkg::COST_W-1:0]        cfg_data,
  input  logic                               q_valid,
  input  sgam_pkg::sgam_item_t               q_item,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [sgam_pkg::SCORE_W-1:0] out_score,
  output logic [1:0]                         out_from,
  output logic                               out_done
);

  localparam int TAB_DEPTH = ALPHABET_SIZE * ALPHABET_SIZE;
  localparam int TAW       = $clog2(TAB_DEPTH);
  localparam int CW        = $clog2(MAX_ROW_LEN);
  localparam int SW        = sgam_pkg::SCORE_W;
  localparam int NW        = sgam_pkg::SUM_W;
  localparam int KW        = sgam_pkg::COST_W;
  localparam int UW        = SW + 1;
  localparam logic [CW-1:0] COL_LAST = CW'(MAX_ROW_LEN - 1);

  // memories: substitution table, upper row {vertical mark, score}
  logic signed [sgam_pkg::WEIGHT_W-1:0] subst_mem [TAB_DEPTH];
  logic [UW-1:0]                        upper_mem [MAX_ROW_LEN];

  // configuration
  logic signed [KW-1:0] gap_start;
  logic signed [KW-1:0] gap_extend;

  // row tracking at the read stage
  logic [CW-1:0] col;
  logic          first_row;

  // scoring stage registers
  logic                                 b_valid;
  logic [CW-1:0]                        b_col;
  logic                                 b_first_row;
  logic                                 b_row_end;
  logic                                 b_final_row;
  logic                                 b_in_alpha;
  logic                                 b_fwd;
  logic [UW-1:0]                        b_fwd_word;
  logic [UW-1:0]                        up_rd;
  logic signed [sgam_pkg::WEIGHT_W-1:0] w_rd;

  // neighbor state
  logic signed [SW-1:0] left_score;
  logic                 left_h;
  logic signed [SW-1:0] diag_score;

  // control
  logic          b_fire;
  logic          pop_cell;
  logic          pop_write;
  logic [TAW-1:0] tab_addr;

  // scoring datapath
  logic [UW-1:0]        up_word;
  logic signed [SW-1:0] up_s;
  logic                 up_v;
  logic signed [NW-1:0] w_ext;
  logic signed [NW-1:0] cand_diag;
  logic signed [NW-1:0] cand_left;
  logic signed [NW-1:0] cand_up;
  logic signed [NW-1:0] left_cost;
  logic signed [NW-1:0] up_cost;
  logic signed [NW-1:0] best;
  logic [1:0]           from;
  logic signed [SW-1:0] sc;

  // write the gap cost registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gap_start  <= -KW'(10);
      gap_extend <= -KW'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        sgam_pkg::CFG_GAP_OPEN:   gap_start  <= cfg_data;
        sgam_pkg::CFG_GAP_EXTEND: gap_extend <= cfg_data;
        default: ;
      endcase
    end
  end

  // pop: writes go at once, cells when the scoring stage frees up
  assign b_fire    = b_valid && (!out_valid || out_ready);
  assign q_pop     = q_valid && (!q_item.is_cell || !b_valid || b_fire);
  assign pop_cell  = q_pop && q_item.is_cell;
  assign pop_write = q_pop && !q_item.is_cell;
  assign tab_addr  = TAW'(q_item.code_first) * TAW'(ALPHABET_SIZE) +
                     TAW'(q_item.code_second);

  // substitution table: write and registered read
  always_ff @(posedge clk) begin
    if (pop_write && q_item.in_alpha) begin
      subst_mem[tab_addr] <= q_item.table_weight;
    end
    if (pop_cell) begin
      w_rd <= subst_mem[tab_addr];
    end
  end

  // upper row: write from scoring stage, registered read at the pop
  always_ff @(posedge clk) begin
    if (b_fire) begin
      upper_mem[b_col] <= {(from == sgam_pkg::FROM_UP), sc};
    end
    if (pop_cell) begin
      up_rd <= upper_mem[col];
    end
  end

  // track column and first row as cells enter
  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      first_row <= 1'b1;
    end else if (pop_cell) begin
      if (q_item.row_end) begin
        col       <= '0;
        first_row <= q_item.final_row;
      end else begin
        col <= (col == COL_LAST) ? '0 : col + 1'b1;
      end
    end
  end

  // load the scoring stage
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (pop_cell) begin
      b_valid <= 1'b1;
    end else if (b_fire) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_cell) begin
      b_col       <= col;
      b_first_row <= first_row;
      b_row_end   <= q_item.row_end;
      b_final_row <= q_item.final_row;
      b_in_alpha  <= q_item.in_alpha;
      // bypass the entry the scoring stage writes at this same edge
      b_fwd       <= b_fire && (b_col == col);
      b_fwd_word  <= {(from == sgam_pkg::FROM_UP), sc};
    end
  end

  // score the cell
  always_comb begin
    up_word   = b_fwd ? b_fwd_word : up_rd;
    up_s      = b_first_row ? '0 : up_word[SW-1:0];
    up_v      = !b_first_row && up_word[SW];
    w_ext     = b_in_alpha ? {{(NW-sgam_pkg::WEIGHT_W){w_rd[sgam_pkg::WEIGHT_W-1]}}, w_rd}
                           : '0;
    left_cost = b_final_row ? '0 :
                (left_h ? {{(NW-KW){gap_extend[KW-1]}}, gap_extend}
                        : {{(NW-KW){gap_start[KW-1]}}, gap_start});
    up_cost   = b_row_end ? '0 :
                (up_v ? {{(NW-KW){gap_extend[KW-1]}}, gap_extend}
                      : {{(NW-KW){gap_start[KW-1]}}, gap_start});
    cand_diag = w_ext + {{(NW-SW){diag_score[SW-1]}}, diag_score};
    cand_left = {{(NW-SW){left_score[SW-1]}}, left_score} + left_cost;
    cand_up   = {{(NW-SW){up_s[SW-1]}}, up_s} + up_cost;

    // ties prefer diagonal, then the upper gap
    if (cand_diag >= cand_left) begin
      if (cand_diag >= cand_up) begin
        best = cand_diag;
        from = sgam_pkg::FROM_DIAG;
      end else begin
        best = cand_up;
        from = sgam_pkg::FROM_UP;
      end
    end else if (cand_left > cand_up) begin
      best = cand_left;
      from = sgam_pkg::FROM_LEFT;
    end else begin
      best = cand_up;
      from = sgam_pkg::FROM_UP;
    end

    // saturate the winner
    if (best > sgam_pkg::SAT_MAX) begin
      sc = sgam_pkg::SAT_MAX[SW-1:0];
    end else if (best < sgam_pkg::SAT_MIN) begin
      sc = sgam_pkg::SAT_MIN[SW-1:0];
    end else begin
      sc = best[SW-1:0];
    end
  end

  // update the neighbor state
  always_ff @(posedge clk) begin
    if (rst) begin
      left_score <= '0;
      left_h     <= 1'b0;
      diag_score <= '0;
    end else if (b_fire) begin
      if (b_row_end) begin
        left_score <= '0;
        left_h     <= 1'b0;
        diag_score <= '0;
      end else begin
        left_score <= sc;
        left_h     <= (from == sgam_pkg::FROM_LEFT);
        diag_score <= up_s;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire) begin
      out_score <= sc;
      out_from  <= from;
      out_done  <= b_row_end && b_final_row;
    end
  end

endmodule

// File: rtl/semiglobal_align_matrix_fill.sv
// ---------------------------------------------------------------------------
// semiglobal_align_matrix_fill
// Semiglobal alignment matrix fill, one cell per request, with a loadable
// substitution table and saturating scores.
// ---------------------------------------------------------------------------
// Throughput: one request per cycle, table writes and cells alike, while the
//   output is not stalled; the left-neighbor add and compare closes in the
//   scoring stage each cycle. Path: a cell's result is registered through the
//   queue, the memory read stage and scoring into the output register.
// Reset: synchronous, active high; clears the queue, pipeline valids, row
//   tracking and neighbor scores and loads the gap costs. Table and row
//   memories are not cleared and hold no data until written.
module semiglobal_align_matrix_fill #(
  parameter int MAX_ROW_LEN   = 1024,
  parameter int ALPHABET_SIZE = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,    // code_first[4:0], code_second[9:5],
                                  // table_weight[25:10], zero pad
  input  logic [1:0]  s_tuser,    // op[0], final_row[1]
  input  logic        s_tlast,    // row_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,    // cell_score[23:0], came_from[25:24], zero pad
  output logic        m_tlast,    // matrix_done
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic                                push;
  logic                                push_ready;
  sgam_pkg::sgam_item_t                push_item;
  logic                                q_valid;
  logic                                q_pop;
  sgam_pkg::sgam_item_t                q_item;
  logic signed [sgam_pkg::SCORE_W-1:0] out_score;
  logic [1:0]                          out_from;

  assign cfg_ready = 1'b1;

  sgam_front #(
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .push      (push),
    .push_ready(push_ready),
    .item      (push_item)
  );

  sgam_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_ready(push_ready),
    .push_item (push_item),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_item  (q_item)
  );

  sgam_back #(
    .MAX_ROW_LEN  (MAX_ROW_LEN),
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_score(out_score),
    .out_from (out_from),
    .out_done (m_tlast)
  );

  // pack the result
  assign m_tdata = {6'b0, out_from, out_score};

endmodule

// File: tb/semiglobal_align_matrix_fill_tb.sv
// ---------------------------------------------------------------------------
// semiglobal_align_matrix_fill_tb
// Drives table-write and cell requests into the semiglobal matrix fill,
// predicts every cell's score, direction and end-of-matrix flag with a local
// copy of the fill state, and checks each result in order. Runs several
// gap-cost settings, each under one of four patterns of sender gaps and
// receiver stalls.
// ---------------------------------------------------------------------------
module semiglobal_align_matrix_fill_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROW_CELLS  = 1024;
  localparam int CYCLE_CAP  = 400000;
  localparam int DRAIN_WAIT = 4;
  localparam longint SCORE_HI = (longint'(1) <<< (sgam_pkg::SCORE_W - 1)) - 1;
  localparam longint SCORE_LO = -(longint'(1) <<< (sgam_pkg::SCORE_W - 1));

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic                                 op;
    logic [sgam_pkg::CODE_W-1:0]          code_a;
    logic [sgam_pkg::CODE_W-1:0]          code_b;
    logic signed [sgam_pkg::WEIGHT_W-1:0] weight;
    logic                                 row_end;
    logic                                 last_row;
  } cell_req_t;

  typedef struct packed {
    logic signed [sgam_pkg::SCORE_W-1:0] score;
    logic [1:0]                          dir;
    logic                                done;
  } cell_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;    // code_first[4:0], code_second[9:5],
                                // table_weight[25:10], zero pad
  logic [1:0]  s_tuser = '0;    // op[0], final_row[1]
  logic        s_tlast = 1'b0;  // row_end
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;         // cell_score[23:0], came_from[25:24], zero pad
  logic        m_tlast;         // matrix_done
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = sgam_pkg::CFG_GAP_OPEN;
  logic [15:0] cfg_data = '0;

  semiglobal_align_matrix_fill dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // stimulus and scoreboard bookkeeping
  cell_req_t   request_q[$];
  cell_res_t   pending_cells[$];
  idle_mode_t  idle_mode = IDLE_NONE;
  bit          req_taken = 1'b0;
  int          requests_open = 0;
  int          items_sent = 0;
  int          writes_sent = 0;
  int          cells_checked = 0;
  int          matrices_done = 0;
  int          settings_run = 1;
  int          errors = 0;
  int unsigned cycle_count = 0;

  // predicted fill state
  logic signed [sgam_pkg::COST_W-1:0]   open_cost = -16'sd10;
  logic signed [sgam_pkg::COST_W-1:0]   ext_cost = -16'sd1;
  logic signed [sgam_pkg::WEIGHT_W-1:0] subst_w [0:ROW_CELLS-1];
  logic signed [sgam_pkg::SCORE_W-1:0]  row_score [0:ROW_CELLS-1];
  bit                                   row_vert [0:ROW_CELLS-1];
  longint                               left_sc = 0;
  bit                                   left_h = 1'b0;
  longint                               diag_sc = 0;
  logic [9:0]                           col_idx = '0;
  bit                                   top_row = 1'b1;

  // generator view of the fill, to keep upper-row reads on written columns
  int          gen_col = 0;
  int          gen_high = 0;
  bit          gen_first = 1'b1;
  bit          table_set [0:ROW_CELLS-1];
  logic [9:0]  table_keys[$];

  // Apply one accepted request: store a table write, or score a cell and queue it.
  function automatic void fill_cell(input cell_req_t rq);
    longint    diag_c;
    longint    left_c;
    longint    up_c;
    longint    up_s;
    longint    best;
    bit        up_v;
    logic [9:0] col;
    cell_res_t res;
    if (rq.op == sgam_pkg::OP_WRITE) begin
      subst_w[{rq.code_a, rq.code_b}] = rq.weight;
    end else begin
      col = col_idx;
      up_s = 0;
      up_v = 1'b0;
      if (!top_row) begin
        up_s = row_score[col];
        up_v = row_vert[col];
      end
      diag_c = longint'(subst_w[{rq.code_a, rq.code_b}]) + diag_sc;
      left_c = left_sc;
      if (!rq.last_row) left_c += left_h ? ext_cost : open_cost;
      up_c = up_s;
      if (!rq.row_end) up_c += up_v ? ext_cost : open_cost;

      // prefer diagonal, then upper gap, on ties
      if (diag_c >= left_c) begin
        if (diag_c >= up_c) begin
          best = diag_c;
          res.dir = sgam_pkg::FROM_DIAG;
        end else begin
          best = up_c;
          res.dir = sgam_pkg::FROM_UP;
        end
      end else if (left_c > up_c) begin
        best = left_c;
        res.dir = sgam_pkg::FROM_LEFT;
      end else begin
        best = up_c;
        res.dir = sgam_pkg::FROM_UP;
      end
      if (best > SCORE_HI) best = SCORE_HI;
      else if (best < SCORE_LO) best = SCORE_LO;
      res.score = best[sgam_pkg::SCORE_W-1:0];
      res.done = rq.row_end && rq.last_row;

      row_score[col] = res.score;
      row_vert[col] = (res.dir == sgam_pkg::FROM_UP);
      diag_sc = up_s;
      left_sc = res.score;
      left_h = (res.dir == sgam_pkg::FROM_LEFT);
      if (rq.row_end) begin
        col_idx = '0;
        left_sc = 0;
        left_h = 1'b0;
        diag_sc = 0;
        top_row = rq.last_row;
      end else begin
        col_idx = col + 10'd1;
      end
      pending_cells.push_back(res);
    end
  endfunction

  function automatic logic [15:0] random_weight();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return 16'($urandom_range(0, 40) - 20);
    endcase
  endfunction

  function automatic logic [9:0] pick_key();
    return table_keys[$urandom_range(0, table_keys.size() - 1)];
  endfunction

  task automatic add_write(input logic [9:0] key, input logic [15:0] w);
    cell_req_t rq;
    rq.op = sgam_pkg::OP_WRITE;
    rq.code_a = key[9:5];
    rq.code_b = key[4:0];
    rq.weight = w;
    rq.row_end = 1'($urandom);
    rq.last_row = 1'($urandom);
    request_q.push_back(rq);
    requests_open++;
    items_sent++;
    writes_sent++;
    if (!table_set[key]) begin
      table_set[key] = 1'b1;
      table_keys.push_back(key);
    end
  endtask

  task automatic add_cell(input logic [9:0] key, input bit re, input bit fr);
    cell_req_t rq;
    rq.op = sgam_pkg::OP_CELL;
    rq.code_a = key[9:5];
    rq.code_b = key[4:0];
    rq.weight = 16'($urandom);
    rq.row_end = re;
    rq.last_row = fr;
    request_q.push_back(rq);
    requests_open++;
    items_sent++;
    if (gen_col + 1 > gen_high) gen_high = gen_col + 1;
    if (re) begin
      gen_col = 0;
      gen_first = fr;
    end else begin
      gen_col = (gen_col + 1) % ROW_CELLS;
    end
  endtask

  // Well-formed matrix of fixed width, with the odd table write mixed in.
  task automatic add_matrix(input int rows, input int width);
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < width; c++) begin
        if ($urandom_range(0, 9) == 0) add_write(10'($urandom), random_weight());
        add_cell(pick_key(), c == width - 1, r == rows - 1);
      end
    end
  endtask

  // Ragged rows and stray last-row flags; close the matrix at the end.
  task automatic add_broken(input int n);
    bit re;
    bit fr;
    for (int i = 0; i < n; i++) begin
      re = ($urandom_range(0, 3) == 0);
      fr = ($urandom_range(0, 2) == 0);
      // end the row before it runs past the columns written so far
      if (!gen_first && gen_col + 1 >= gen_high) re = 1'b1;
      add_cell(pick_key(), re, fr);
    end
    add_cell(pick_key(), 1'b1, 1'b1);
  endtask

  task automatic random_phase(input int target);
    int start;
    start = items_sent;
    while (items_sent - start < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6:
          add_matrix($urandom_range(1, 6),
                     ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40)
                                                 : $urandom_range(1, 8));
        7: add_broken($urandom_range(3, 12));
        default: repeat ($urandom_range(1, 4)) add_write(10'($urandom), random_weight());
      endcase
    end
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == sgam_pkg::CFG_GAP_OPEN) open_cost = val;
    else ext_cost = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_costs(input logic [15:0] gap_start, input logic [15:0] gap_ext);
    write_reg(sgam_pkg::CFG_GAP_OPEN, gap_start);
    write_reg(sgam_pkg::CFG_GAP_EXTEND, gap_ext);
    settings_run++;
  endtask

  // Hold until every request is taken and every cell has come back.
  task automatic wait_drained();
    while (requests_open != 0 || pending_cells.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // Drive requests and output backpressure on the falling edge.
  always @(negedge clk) begin : drive_requests
    cell_req_t rq;
    bit        send_gap;
    bit        recv_stall;
    send_gap = (idle_mode == IDLE_SEND && $urandom_range(0, 99) < 64) ||
               (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 7);
    recv_stall = (idle_mode == IDLE_RECV && $urandom_range(0, 99) < 64) ||
                 (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 7);
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      // advance only once the held request is taken
      if (!s_tvalid || req_taken) begin
        if (request_q.size() != 0 && !send_gap) begin
          rq = request_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {6'b0, rq.weight, rq.code_b, rq.code_a};
          s_tuser <= {rq.last_row, rq.op};
          s_tlast <= rq.row_end;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= !recv_stall;
    end
  end

  // Sample both handshakes on the rising edge; predict and check.
  always @(posedge clk) begin : watch_ports
    cell_req_t seen;
    cell_res_t want;
    cycle_count++;
    if (cycle_count >= CYCLE_CAP) begin
      $display("%0t: run exceeded %0d cycles, %0d cells still expected",
               $time, CYCLE_CAP, pending_cells.size());
      $display("Simulation FAILED");
      $finish;
    end else if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        seen.op = s_tuser[0];
        seen.code_a = s_tdata[4:0];
        seen.code_b = s_tdata[9:5];
        seen.weight = s_tdata[25:10];
        seen.row_end = s_tlast;
        seen.last_row = s_tuser[1];
        fill_cell(seen);
        requests_open--;
      end
      if (m_tvalid && m_tready) begin
        if (pending_cells.size() == 0) begin
          $display("%0t: unexpected cell, expected none, got tdata %h tlast %b",
                   $time, m_tdata, m_tlast);
          errors++;
        end else begin
          want = pending_cells.pop_front();
          if (m_tdata[23:0] !== want.score) begin
            $display("%0t: cell_score expected %0d got %0d", $time,
                     want.score, $signed(m_tdata[23:0]));
            errors++;
          end
          if (m_tdata[25:24] !== want.dir) begin
            $display("%0t: came_from expected %0d got %0d", $time,
                     want.dir, m_tdata[25:24]);
            errors++;
          end
          if (m_tlast !== want.done) begin
            $display("%0t: matrix_done expected %b got %b", $time,
                     want.done, m_tlast);
            errors++;
          end
          cells_checked++;
          if (want.done) matrices_done++;
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extreme weights, a 3x3 matrix with a mid-row write, a
    // one-cell matrix right after an end, and a row that is the last row.
    idle_mode = IDLE_NONE;
    add_write({5'd0, 5'd0}, 16'h7fff);
    add_write({5'd31, 5'd31}, 16'h8000);
    add_write({5'd0, 5'd31}, 16'd5);
    add_write({5'd31, 5'd0}, 16'hfff9);
    add_write({5'd21, 5'd10}, 16'h5555);
    add_write({5'd10, 5'd21}, 16'haaaa);
    add_cell({5'd0, 5'd0}, 1'b0, 1'b0);
    add_cell({5'd21, 5'd10}, 1'b0, 1'b0);
    add_cell({5'd31, 5'd31}, 1'b1, 1'b0);
    add_cell({5'd0, 5'd31}, 1'b0, 1'b0);
    add_write({5'd10, 5'd21}, 16'd3);
    add_cell({5'd10, 5'd21}, 1'b0, 1'b0);
    add_cell({5'd0, 5'd0}, 1'b1, 1'b0);
    add_cell({5'd31, 5'd0}, 1'b0, 1'b1);
    add_cell({5'd0, 5'd0}, 1'b0, 1'b1);
    add_cell({5'd21, 5'd10}, 1'b1, 1'b1);
    add_cell({5'd0, 5'd0}, 1'b1, 1'b1);
    add_cell({5'd31, 5'd31}, 1'b0, 1'b1);
    add_cell({5'd0, 5'd31}, 1'b1, 1'b1);
    wait_drained();

    // Most negative open cost, most positive extend cost; sender gaps.
    set_costs(16'h8000, 16'h7fff);
    idle_mode = IDLE_SEND;
    random_phase(50);
    wait_drained();

    // Reversed extremes; receiver stalls.
    set_costs(16'h7fff, 16'h8000);
    idle_mode = IDLE_RECV;
    random_phase(50);
    wait_drained();

    // Random costs; light gaps on both sides.
    set_costs(random_weight(), random_weight());
    idle_mode = IDLE_BOTH;
    random_phase(50);
    wait_drained();

    // Positive gap costs over a row longer than the row store: the left
    // chain saturates and the column index wraps.
    set_costs(16'h7fff, 16'h7fff);
    idle_mode = IDLE_NONE;
    for (int c = 0; c < ROW_CELLS + 6; c++) begin
      add_cell(pick_key(), c == ROW_CELLS + 5, c == ROW_CELLS + 5);
    end
    wait_drained();

    // Random costs again; receiver stalls.
    set_costs(random_weight(), random_weight());
    idle_mode = IDLE_RECV;
    random_phase(50);
    wait_drained();

    repeat (8) @(negedge clk);
    $display("Checked %0d cells over %0d matrices, with %0d table writes,",
             cells_checked, matrices_done, writes_sent);
    $display("under %0d gap-cost settings and four idle patterns", settings_run);
    if (errors == 0 && pending_cells.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
